// ----- rtl/tpt_pkg.sv -----
package tpt_pkg;

    localparam int DIR_IDX_W  = 10;
    localparam int TBL_IDX_W  = 10;
    localparam int OFF_W      = 12;
    localparam int FRAME_W    = 10;
    localparam int PHYS_W     = 22;
    localparam int PROC_W     = 4;
    localparam int VADDR_W    = 32;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    localparam int DF_BIT     = 22;
    localparam int TF_BIT     = 23;
    localparam int NOFR_BIT   = 24;
    localparam int NOTB_BIT   = 25;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_TBL
    } t_state;

endpackage

// ----- rtl/tpt_ram.sv -----
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/two_level_page_translation.sv -----
// A taken beat goes to ST_DIR with a registered directory read (none for a process
// index out of range, its result registered there as for a used-up table pool);
// a full walk goes on to ST_TBL, a registered read of the table memory. A beat is
// taken as a result is registered: one a cycle, while the output is not stalled,
// for beats ending after the directory read. Reset: synchronous, active low; no beat
// is taken while both memories are cleared, max(PROCS, TABLE_POOL) * 1024 entries.
module two_level_page_translation
    import tpt_pkg::*;
#(
    parameter int PROCS      = 16,
    parameter int FRAMES     = 1024,
    parameter int TABLE_POOL = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [3:0] proc_index, [35:4] virt_addr, [39:36] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [21:0] phys_addr, [22] dir_fault, [23] table_fault,
    // [24] out_of_frames, [25] out_of_tables, [31:26] zero
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int DIR_DEPTH = PROCS * 1024;
    localparam int DIR_AW    = $clog2(DIR_DEPTH);
    localparam int SLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int TBL_DEPTH = TABLE_POOL * 1024;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int NSLOT_W   = $clog2(TABLE_POOL + 1);
    localparam int HEAD_W    = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int CLR_DEPTH = (DIR_DEPTH > TBL_DEPTH) ? DIR_DEPTH : TBL_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int DIR_DW    = SLOT_W + 1;
    localparam int TBL_DW    = FRAME_W + 1;

    t_state               r_state, n_state;
    logic [CLR_W-1:0]     r_clr, n_clr;
    logic                 r_oor, n_oor;
    logic                 r_dfault, n_dfault;
    logic [DIR_AW-1:0]    r_dir_addr, n_dir_addr;
    logic [TBL_AW-1:0]    r_tbl_addr, n_tbl_addr;
    logic [TBL_IDX_W-1:0] r_ti, n_ti;
    logic [OFF_W-1:0]     r_off, n_off;
    logic [NSLOT_W-1:0]   r_next_slot, n_next_slot;
    logic [HEAD_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]     r_free, n_free;
    logic                 r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    logic                 dir_we, dir_re, tbl_we, tbl_re;
    logic [DIR_AW-1:0]    dir_waddr, dir_raddr;
    logic [TBL_AW-1:0]    tbl_waddr, tbl_raddr;
    logic [DIR_DW-1:0]    dir_wdata, dir_rdata;
    logic [TBL_DW-1:0]    tbl_wdata, tbl_rdata;

    logic [PROC_W-1:0]    in_proc;
    logic [VADDR_W-1:0]   in_va;
    logic                 in_oor;
    logic                 out_free;
    logic                 finish;
    logic                 dir_hit, slot_avail, tbl_hit, frame_avail;
    logic [SLOT_W-1:0]    slot;
    logic [FRAME_W-1:0]   frame;
    logic [PHYS_W-1:0]    phys;

    tpt_ram #(
        .WIDTH (DIR_DW),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_re    (dir_re),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    tpt_ram #(
        .WIDTH (TBL_DW),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign in_proc     = i_s_tdata[PROC_W-1:0];
    assign in_va       = i_s_tdata[PROC_W +: VADDR_W];
    assign in_oor      = 32'(in_proc) >= 32'(PROCS);
    assign out_free    = !r_out_valid || i_m_tready;

    assign dir_hit     = dir_rdata[SLOT_W];
    assign slot_avail  = 32'(r_next_slot) < 32'(TABLE_POOL);
    assign slot        = dir_hit ? dir_rdata[SLOT_W-1:0] : SLOT_W'(r_next_slot);
    assign tbl_hit     = tbl_rdata[FRAME_W];
    assign frame_avail = r_free != '0;
    assign frame       = tbl_hit ? tbl_rdata[FRAME_W-1:0] : FRAME_W'(r_head);
    assign phys        = (tbl_hit || frame_avail) ? {frame[FRAME_W-1:0], r_off} : '0;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_oor       = r_oor;
        n_dfault    = r_dfault;
        n_dir_addr  = r_dir_addr;
        n_tbl_addr  = r_tbl_addr;
        n_ti        = r_ti;
        n_off       = r_off;
        n_next_slot = r_next_slot;
        n_head      = r_head;
        n_free      = r_free;
        n_out_data  = r_out_data;
        dir_we      = 1'b0;
        dir_waddr   = r_dir_addr;
        dir_wdata   = '0;
        dir_re      = 1'b0;
        dir_raddr   = DIR_AW'({in_proc, in_va[VADDR_W-1 -: DIR_IDX_W]});
        tbl_we      = 1'b0;
        tbl_waddr   = r_tbl_addr;
        tbl_wdata   = '0;
        tbl_re      = 1'b0;
        tbl_raddr   = TBL_AW'({slot, r_ti});
        o_s_tready  = 1'b0;
        finish      = 1'b0;
        n_out_valid = i_m_tready ? 1'b0 : r_out_valid;

        unique case (r_state)
            ST_CLEAR: begin
                dir_we    = 32'(r_clr) < 32'(DIR_DEPTH);
                dir_waddr = DIR_AW'(r_clr);
                tbl_we    = 32'(r_clr) < 32'(TBL_DEPTH);
                tbl_waddr = TBL_AW'(r_clr);
                n_clr     = r_clr + 1'b1;
                if (r_clr == CLR_W'(CLR_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_DIR: begin
                if (r_oor) begin
                    finish     = 1'b1;
                    n_out_data = '0;
                end else if (!dir_hit && !slot_avail) begin
                    finish     = 1'b1;
                    n_out_data = M_TDATA_W'({1'b1, 1'b0, 1'b0, 1'b1, PHYS_W'(0)});
                end else begin
                    if (!dir_hit) begin
                        dir_we      = 1'b1;
                        dir_wdata   = {1'b1, SLOT_W'(r_next_slot)};
                        n_next_slot = r_next_slot + 1'b1;
                    end
                    tbl_re     = 1'b1;
                    n_tbl_addr = tbl_raddr;
                    n_dfault   = !dir_hit;
                    n_state    = ST_TBL;
                end
            end
            ST_TBL: begin
                finish     = 1'b1;
                n_out_data = M_TDATA_W'({1'b0, !tbl_hit && !frame_avail, !tbl_hit,
                                         r_dfault, phys});
                if (out_free && !tbl_hit && frame_avail) begin
                    tbl_we    = 1'b1;
                    tbl_wdata = {1'b1, FRAME_W'(r_head)};
                    n_head    = (r_head == HEAD_W'(FRAMES - 1)) ? '0 : r_head + 1'b1;
                    n_free    = r_free - 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        if (finish) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                o_s_tready  = 1'b1;
                n_state     = ST_IDLE;
            end else begin
                n_out_data = r_out_data;
            end
        end

        if (o_s_tready && i_s_tvalid) begin
            n_oor      = in_oor;
            n_dir_addr = dir_raddr;
            n_ti       = in_va[OFF_W +: TBL_IDX_W];
            n_off      = in_va[OFF_W-1:0];
            dir_re     = !in_oor;
            n_state    = ST_DIR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_next_slot <= '0;
            r_head      <= '0;
            r_free      <= CNT_W'(FRAMES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_slot <= n_next_slot;
            r_head      <= n_head;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_oor      <= n_oor;
        r_dfault   <= n_dfault;
        r_dir_addr <= n_dir_addr;
        r_tbl_addr <= n_tbl_addr;
        r_ti       <= n_ti;
        r_off      <= n_off;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- rtl/tpt_chk.sv -----
module tpt_chk
    import tpt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("outputs active right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");

    a_no_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[NOTB_BIT] |-> o_m_tdata[DF_BIT] && !o_m_tdata[TF_BIT]
            && !o_m_tdata[NOFR_BIT] && o_m_tdata[PHYS_W-1:0] == '0)
        else $error("inconsistent flags on a used-up table pool");

    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[NOFR_BIT] |-> o_m_tdata[TF_BIT]
            && o_m_tdata[PHYS_W-1:0] == '0)
        else $error("inconsistent flags on an empty frame ring");

endmodule

bind two_level_page_translation tpt_chk u_tpt_chk (.*);

// ----- bench/tb_top.sv -----
module tb_top;
    import tpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PROCS        = 16;
    localparam int N_FRAMES       = 1024;
    localparam int N_SLOTS        = 64;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic              out_of_tables;
        logic              out_of_frames;
        logic              table_fault;
        logic              dir_fault;
        logic [PHYS_W-1:0] phys;
    } t_walk_result;

    localparam int RES_W = $bits(t_walk_result);

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    // [3:0] proc_index, [35:4] virt_addr, [39:36] zero
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    // [21:0] phys_addr, [22] dir_fault, [23] table_fault,
    // [24] out_of_frames, [25] out_of_tables, [31:26] zero
    logic [M_TDATA_W-1:0] o_m_tdata;

    two_level_page_translation #(
        .PROCS(N_PROCS),
        .FRAMES(N_FRAMES),
        .TABLE_POOL(N_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    // Shadow page tables of the translator.
    bit                       dir_valid   [N_PROCS*1024];
    logic [5:0]               dir_slot    [N_PROCS*1024];
    bit                       entry_valid [N_SLOTS*1024];
    logic [FRAME_W-1:0]       entry_frame [N_SLOTS*1024];
    int                       slots_used  = 0;
    logic [FRAME_W-1:0]       ring_head   = '0;
    int                       frames_free = N_FRAMES;

    logic [13:0]              known_dirs[$];
    logic [23:0]              mapped_pages[$];
    t_walk_result             pending_walks[$];

    int walks_sent     = 0;
    int beats_checked  = 0;
    int mismatches     = 0;
    int n_dir_faults   = 0;
    int n_table_faults = 0;
    int n_ring_empty   = 0;
    int n_pool_empty   = 0;
    int src_max_gap    = 3;
    int sink_max_stall = 3;
    int sink_hold      = 0;
    int quiet_cycles   = 0;

    function automatic t_walk_result translate_walk(input logic [PROC_W-1:0] proc,
                                                    input logic [VADDR_W-1:0] va);
        t_walk_result res;
        logic [13:0]  dpos;
        logic [15:0]  epos;
        res = '0;
        if (proc < N_PROCS) begin
            dpos = {proc, va[31:22]};
            if (!dir_valid[dpos]) begin
                res.dir_fault = 1'b1;
                if (slots_used < N_SLOTS) begin
                    dir_slot[dpos]  = slots_used[5:0];
                    dir_valid[dpos] = 1'b1;
                    slots_used++;
                    known_dirs.push_back(dpos);
                end else begin
                    res.out_of_tables = 1'b1;
                end
            end
            if (dir_valid[dpos]) begin
                epos = {dir_slot[dpos], va[21:12]};
                if (!entry_valid[epos]) begin
                    res.table_fault = 1'b1;
                    if (frames_free > 0) begin
                        // The free ring is never refilled, so the frame at the
                        // head is the head index itself; it wraps at 1024.
                        entry_frame[epos] = ring_head;
                        entry_valid[epos] = 1'b1;
                        ring_head         = ring_head + 1'b1;
                        frames_free--;
                        mapped_pages.push_back({proc, va[31:12]});
                    end else begin
                        res.out_of_frames = 1'b1;
                    end
                end
                if (entry_valid[epos]) begin
                    res.phys = {entry_frame[epos], va[11:0]};
                end
            end
        end
        n_dir_faults   += res.dir_fault;
        n_table_faults += res.table_fault;
        n_ring_empty   += res.out_of_frames;
        n_pool_empty   += res.out_of_tables;
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_walk(input logic [PROC_W-1:0] proc,
                             input logic [VADDR_W-1:0] va);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, va, proc};
        do @(posedge i_clk); while (!o_s_tready);
        pending_walks.push_back(translate_walk(proc, va));
        walks_sent++;
    endtask

    task automatic send_mixed(input int hit_pct, input int page_pct);
        int          r;
        logic [23:0] pg;
        logic [13:0] d;
        r = $urandom_range(0, 99);
        if (r < hit_pct && mapped_pages.size() > 0) begin
            pg = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
            send_walk(pg[23:20], {pg[19:0], 12'($urandom)});
        end else if (r < hit_pct + page_pct && known_dirs.size() > 0) begin
            d = known_dirs[$urandom_range(0, known_dirs.size() - 1)];
            send_walk(d[13:10], {d[9:0], 10'($urandom), 12'($urandom)});
        end else begin
            send_walk(4'($urandom), $urandom);
        end
    endtask

    task automatic test_directed;
        send_walk(4'd0,  32'h0000_0000);
        send_walk(4'd0,  32'h0000_0FFF);
        send_walk(4'd15, 32'hFFFF_FFFF);
        send_walk(4'd15, 32'hFFFF_F000);
        send_walk(4'd0,  32'h0000_1ABC);
        send_walk(4'd1,  32'h0000_0123);
        send_walk(4'd0,  32'h0040_0000);
        send_walk(4'd15, 32'hFFC0_0000);
        send_walk(4'd15, 32'h003F_F000);
        send_walk(4'd10, 32'hAAAA_AAAA);
        send_walk(4'd5,  32'h5555_5555);
        send_walk(4'd10, 32'hAAAA_A555);
        send_walk(4'd5,  32'h5555_5AAA);
        send_walk(4'd0,  32'h0000_0800);
        send_walk(4'd1,  32'h0000_0FFF);
        send_walk(4'd15, 32'hFFFF_F7FF);
    endtask

    task automatic test_mixed_traffic(input int count, input int hit_pct,
                                      input int page_pct);
        for (int k = 0; k < count; k++) begin
            send_mixed(hit_pct, page_pct);
        end
    endtask

    task automatic test_backpressure;
        src_max_gap = 0;
        sink_hold   = 400;
        for (int k = 0; k < 40; k++) begin
            send_mixed(30, 65);
        end
        src_max_gap = 3;
    endtask

    task automatic test_back_to_back;
        src_max_gap    = 0;
        sink_max_stall = 0;
        test_mixed_traffic(150, 40, 55);
        src_max_gap    = 3;
        sink_max_stall = 3;
    endtask

    task automatic test_frame_ring_empty;
        int          guard;
        logic [13:0] d;
        logic [23:0] pg;
        guard = 0;
        while ((frames_free > 0 || guard < 1) && guard < 3000) begin
            d = known_dirs[$urandom_range(0, known_dirs.size() - 1)];
            send_walk(d[13:10], {d[9:0], 10'($urandom), 12'($urandom)});
            guard++;
        end
        for (int k = 0; k < 12; k++) begin
            d = known_dirs[$urandom_range(0, known_dirs.size() - 1)];
            send_walk(d[13:10], {d[9:0], 10'($urandom), 12'($urandom)});
        end
        for (int k = 0; k < 8; k++) begin
            pg = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
            send_walk(pg[23:20], {pg[19:0], 12'($urandom)});
        end
    endtask

    task automatic test_table_pool_empty;
        logic [13:0] d;
        int          extra;
        extra = 0;
        while (extra < 10) begin
            do d = 14'($urandom); while (dir_valid[d]);
            if (slots_used >= N_SLOTS) begin
                extra++;
            end
            send_walk(d[13:10], {d[9:0], 22'($urandom)});
        end
    endtask

    initial begin : sink
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                i_m_tready <= 1'b0;
                repeat (sink_hold) @(negedge i_clk);
                sink_hold = 0;
            end else begin
                stall = $urandom_range(0, sink_max_stall);
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_walk_result want;
        t_walk_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_walk_result'(o_m_tdata[RES_W-1:0]);
            beats_checked++;
            if (pending_walks.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("tb_top: result beat with no walk pending: %h", o_m_tdata);
                end
            end else begin
                want = pending_walks.pop_front();
                if (got !== want || o_m_tdata[M_TDATA_W-1:RES_W] !== '0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display({"tb_top: mismatch at beat %0d: expected phys=%h df=%b",
                                  " tf=%b nofr=%b notb=%b"},
                                 beats_checked, want.phys, want.dir_fault,
                                 want.table_fault, want.out_of_frames, want.out_of_tables);
                        $display({"tb_top:   got phys=%h df=%b tf=%b nofr=%b notb=%b",
                                  " pad=%h"},
                                 got.phys, got.dir_fault, got.table_fault,
                                 got.out_of_frames, got.out_of_tables,
                                 o_m_tdata[M_TDATA_W-1:RES_W]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: no beat moved for %0d cycles, %0d walks outstanding",
                     quiet_cycles, pending_walks.size());
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_mixed_traffic(600, 40, 55);
        test_backpressure();
        test_back_to_back();
        test_frame_ring_empty();
        test_table_pool_empty();
        test_mixed_traffic(250, 40, 30);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_walks.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("tb_top: %0d walks sent, %0d result beats checked, %0d mismatches",
                 walks_sent, beats_checked, mismatches);
        $display({"tb_top: %0d directory faults, %0d table faults,",
                  " %0d with no frame, %0d with no table"},
                 n_dir_faults, n_table_faults, n_ring_empty, n_pool_empty);
        if (mismatches == 0 && pending_walks.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
